>>> sv/pbpu_pkg.sv
// Shared types, constants and helper functions of the pixel bitfield pack and unpack unit.
`timescale 1ns / 1ps

package pbpu_pkg;

    localparam int MAX_CHANNELS_DEF = 4;
    localparam int CHAN_COUNT       = 4;
    localparam int CHAN_BITS        = 8;
    localparam int WORD_BYTES       = 4;
    localparam int BYTE_BITS        = 8;
    localparam int WORD_BITS        = WORD_BYTES * BYTE_BITS;
    localparam int HB_BITS          = $clog2(WORD_BITS);
    localparam int TOP_BIT          = 7;
    localparam int CFG_INDEX_BITS   = 3;
    localparam int BPP_BITS         = 3;
    localparam int CC_BITS          = 3;

    localparam logic [WORD_BITS-1:0] MASK0_RST = 32'h00FF_0000;
    localparam logic [WORD_BITS-1:0] MASK1_RST = 32'h0000_FF00;
    localparam logic [WORD_BITS-1:0] MASK2_RST = 32'h0000_00FF;
    localparam logic [WORD_BITS-1:0] MASK3_RST = 32'h0000_0000;
    localparam logic [BPP_BITS-1:0]  BPP_RST   = 3'd3;
    localparam logic [CC_BITS-1:0]   CC_RST    = 3'd3;
    localparam logic                 LE_RST    = 1'b1;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_MASK_0          = 3'd0,
        CFG_MASK_1          = 3'd1,
        CFG_MASK_2          = 3'd2,
        CFG_MASK_3          = 3'd3,
        CFG_BYTES_PER_PIXEL = 3'd4,
        CFG_CHANNEL_COUNT   = 3'd5,
        CFG_LITTLE_ENDIAN   = 3'd6
    } cfg_index_t;

    typedef enum logic {
        OP_PACK   = 1'b0,
        OP_UNPACK = 1'b1
    } opcode_t;

    typedef struct packed {
        logic                 opcode;
        logic [CHAN_BITS-1:0] chan_in_0;
        logic [CHAN_BITS-1:0] chan_in_1;
        logic [CHAN_BITS-1:0] chan_in_2;
        logic [CHAN_BITS-1:0] chan_in_3;
        logic [WORD_BITS-1:0] packed_in;
        logic                 last_in;
    } in_word_t;

    typedef struct packed {
        logic [WORD_BITS-1:0] packed_out;
        logic [CHAN_BITS-1:0] chan_out_0;
        logic [CHAN_BITS-1:0] chan_out_1;
        logic [CHAN_BITS-1:0] chan_out_2;
        logic [CHAN_BITS-1:0] chan_out_3;
        logic                 last_out;
    } out_word_t;

    typedef struct packed {
        logic    load;
        opcode_t opcode;
    } lane_ctrl_t;

    typedef struct packed {
        logic                load;
        opcode_t             opcode;
        logic                last;
        logic [BPP_BITS-1:0] nbytes;
        logic                little_endian;
    } merge_ctrl_t;

    function automatic logic [HB_BITS-1:0] top_set_bit(input logic [WORD_BITS-1:0] m);
        logic [HB_BITS-1:0] hb;
        hb = '0;
        for (int b = 0; b < WORD_BITS; b++) begin
            if (m[b]) begin
                hb = HB_BITS'(b);
            end
        end
        return hb;
    endfunction

    // Output byte j takes input byte j (little endian) or nbytes-1-j (big endian);
    // bytes at and above nbytes are zero.
    function automatic logic [WORD_BITS-1:0] byte_order(input logic [WORD_BITS-1:0] w,
                                                        input logic [BPP_BITS-1:0]  nbytes,
                                                        input logic                 le);
        logic [WORD_BITS-1:0] res;
        logic [BPP_BITS-1:0]  sh;
        res = '0;
        for (int j = 0; j < WORD_BYTES; j++) begin
            sh = le ? BPP_BITS'(j) : BPP_BITS'(nbytes - BPP_BITS'(1) - BPP_BITS'(j));
            if (BPP_BITS'(j) < nbytes) begin
                res[BYTE_BITS*j +: BYTE_BITS] = w[BYTE_BITS*sh[1:0] +: BYTE_BITS];
            end
        end
        return res;
    endfunction

endpackage

>>> sv/pbpu_lane.sv
// One channel lane: aligns a channel value to its mask or extracts it from the word.
`timescale 1ns / 1ps

module pbpu_lane (
    input  logic                                 aclk,
    input  pbpu_pkg::lane_ctrl_t                 ctrl,
    input  logic                                 enable,
    input  logic [pbpu_pkg::CHAN_BITS-1:0]       chan_in,
    input  logic [pbpu_pkg::WORD_BITS-1:0]       word_in,
    input  logic [pbpu_pkg::WORD_BITS-1:0]       mask,
    input  logic [pbpu_pkg::HB_BITS-1:0]         hb,
    output logic [pbpu_pkg::WORD_BITS-1:0]       word_out,
    output logic [pbpu_pkg::CHAN_BITS-1:0]       chan_out
);
    import pbpu_pkg::*;

    logic [WORD_BITS-1:0] up_val;
    logic [WORD_BITS-1:0] down_val;
    logic [WORD_BITS-1:0] word_next;
    logic [WORD_BITS-1:0] word_reg;
    logic [CHAN_BITS-1:0] chan_next;
    logic [CHAN_BITS-1:0] chan_reg;
    logic [WORD_BITS-1:0] chan_wide;
    logic [WORD_BITS-1:0] field;

    assign chan_wide = {{(WORD_BITS-CHAN_BITS){1'b0}}, chan_in};
    assign field     = word_in & mask;

    always_comb begin
        if (hb >= HB_BITS'(TOP_BIT)) begin
            up_val   = chan_wide << (hb - HB_BITS'(TOP_BIT));
            down_val = field >> (hb - HB_BITS'(TOP_BIT));
        end else begin
            up_val   = chan_wide >> (HB_BITS'(TOP_BIT) - hb);
            down_val = field << (HB_BITS'(TOP_BIT) - hb);
        end
    end

    always_comb begin
        word_next = '0;
        chan_next = '0;
        if (enable) begin
            unique case (ctrl.opcode)
                OP_PACK:   word_next = up_val & mask;
                OP_UNPACK: chan_next = down_val[CHAN_BITS-1:0];
                default:   word_next = '0;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            word_reg <= word_next;
            chan_reg <= chan_next;
        end
    end

    assign word_out = word_reg;
    assign chan_out = chan_reg;

endmodule

>>> sv/pbpu_merge.sv
// Merge stage: combines the lane results into one output word.
`timescale 1ns / 1ps

module pbpu_merge #(
    parameter int MAX_CHANNELS = pbpu_pkg::MAX_CHANNELS_DEF
) (
    input  logic                            aclk,
    input  pbpu_pkg::merge_ctrl_t           ctrl,
    input  logic [pbpu_pkg::WORD_BITS-1:0]  lane_word [MAX_CHANNELS],
    input  logic [pbpu_pkg::CHAN_BITS-1:0]  lane_chan [MAX_CHANNELS],
    output pbpu_pkg::out_word_t             m_word
);
    import pbpu_pkg::*;

    logic [WORD_BITS-1:0] word_or;
    logic [CHAN_BITS-1:0] chans [CHAN_COUNT];
    out_word_t            out_next;
    out_word_t            out_reg;

    always_comb begin
        word_or = '0;
        for (int i = 0; i < CHAN_COUNT; i++) begin
            chans[i] = '0;
        end
        for (int i = 0; i < MAX_CHANNELS; i++) begin
            word_or  = word_or | lane_word[i];
            chans[i] = lane_chan[i];
        end
    end

    always_comb begin
        out_next            = '0;
        out_next.last_out   = ctrl.last;
        unique case (ctrl.opcode)
            OP_PACK: begin
                out_next.packed_out = byte_order(word_or, ctrl.nbytes, ctrl.little_endian);
            end
            OP_UNPACK: begin
                out_next.chan_out_0 = chans[0];
                out_next.chan_out_1 = chans[1];
                out_next.chan_out_2 = chans[2];
                out_next.chan_out_3 = chans[3];
            end
            default: out_next.packed_out = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            out_reg <= out_next;
        end
    end

    assign m_word = out_reg;

endmodule

>>> sv/pixel_bitfield_pack_unpack_unit.sv
// Top level of the pixel bitfield pack and unpack unit with configuration registers.
// The unit converts one pixel per clock, when the output is not stalled, between four
// 8-bit channels and a packed word of 1 to 4 bytes, in either direction chosen per
// word by the opcode. Every word passes through two register stages: the channel
// lanes, which align each channel against its mask in parallel, and the merge
// stage, which combines the lanes and, for packing, puts the bytes in stream order.
// A new word is accepted every clock while the output side keeps taking results;
// two register stages absorb a stall. Configuration writes are always accepted and
// must only be made while no word is in flight; there is no clearing pass after reset.
`timescale 1ns / 1ps

module pixel_bitfield_pack_unpack_unit #(
    parameter int MAX_CHANNELS = pbpu_pkg::MAX_CHANNELS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  pbpu_pkg::in_word_t                   s_word,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output pbpu_pkg::out_word_t                  m_word,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [pbpu_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [pbpu_pkg::WORD_BITS-1:0]       cfg_data
);
    import pbpu_pkg::*;

    logic [WORD_BITS-1:0] mask_reg  [CHAN_COUNT];
    logic [WORD_BITS-1:0] mask_next [CHAN_COUNT];
    logic [HB_BITS-1:0]   hb_reg    [CHAN_COUNT];
    logic [BPP_BITS-1:0]  bpp_reg, bpp_next;
    logic [CC_BITS-1:0]   cc_reg, cc_next;
    logic                 le_reg, le_next;

    logic [BPP_BITS-1:0]  nbytes;
    logic [CC_BITS-1:0]   nchan;

    logic                 v1_reg, v1_next;
    logic                 v2_reg, v2_next;
    logic                 ready1;
    logic                 ld1;
    logic                 ld2;
    opcode_t              op1_reg;
    logic                 last1_reg;

    logic [CHAN_BITS-1:0] chan_in [CHAN_COUNT];
    logic [WORD_BITS-1:0] unpack_word;
    logic [WORD_BITS-1:0] lane_word [MAX_CHANNELS];
    logic [CHAN_BITS-1:0] lane_chan [MAX_CHANNELS];
    lane_ctrl_t           lane_ctrl;
    merge_ctrl_t          merge_ctrl;

    assign cfg_ready = 1'b1;

    always_comb begin
        for (int i = 0; i < CHAN_COUNT; i++) begin
            mask_next[i] = mask_reg[i];
        end
        bpp_next = bpp_reg;
        cc_next  = cc_reg;
        le_next  = le_reg;
        if (cfg_valid) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_MASK_0:          mask_next[0] = cfg_data;
                CFG_MASK_1:          mask_next[1] = cfg_data;
                CFG_MASK_2:          mask_next[2] = cfg_data;
                CFG_MASK_3:          mask_next[3] = cfg_data;
                CFG_BYTES_PER_PIXEL: bpp_next     = cfg_data[BPP_BITS-1:0];
                CFG_CHANNEL_COUNT:   cc_next      = cfg_data[CC_BITS-1:0];
                CFG_LITTLE_ENDIAN:   le_next      = cfg_data[0];
                default:             le_next      = le_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg[0] <= MASK0_RST;
            mask_reg[1] <= MASK1_RST;
            mask_reg[2] <= MASK2_RST;
            mask_reg[3] <= MASK3_RST;
            hb_reg[0]   <= top_set_bit(MASK0_RST);
            hb_reg[1]   <= top_set_bit(MASK1_RST);
            hb_reg[2]   <= top_set_bit(MASK2_RST);
            hb_reg[3]   <= top_set_bit(MASK3_RST);
            bpp_reg     <= BPP_RST;
            cc_reg      <= CC_RST;
            le_reg      <= LE_RST;
        end else begin
            for (int i = 0; i < CHAN_COUNT; i++) begin
                mask_reg[i] <= mask_next[i];
                hb_reg[i]   <= top_set_bit(mask_next[i]);
            end
            bpp_reg <= bpp_next;
            cc_reg  <= cc_next;
            le_reg  <= le_next;
        end
    end

    always_comb begin
        if (bpp_reg == '0) begin
            nbytes = BPP_BITS'(1);
        end else if (bpp_reg > BPP_BITS'(WORD_BYTES)) begin
            nbytes = BPP_BITS'(WORD_BYTES);
        end else begin
            nbytes = bpp_reg;
        end
        if (cc_reg == '0) begin
            nchan = CC_BITS'(1);
        end else if (cc_reg > CC_BITS'(MAX_CHANNELS)) begin
            nchan = CC_BITS'(MAX_CHANNELS);
        end else begin
            nchan = cc_reg;
        end
    end

    assign ready1  = !v2_reg || m_ready;
    assign s_ready = !v1_reg || ready1;
    assign ld1     = s_valid && s_ready;
    assign ld2     = v1_reg && ready1;
    assign m_valid = v2_reg;

    always_comb begin
        v1_next = v1_reg;
        v2_next = v2_reg;
        if (ld1) begin
            v1_next = 1'b1;
        end else if (ld2) begin
            v1_next = 1'b0;
        end
        if (ld2) begin
            v2_next = 1'b1;
        end else if (m_ready) begin
            v2_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ld1) begin
            op1_reg   <= opcode_t'(s_word.opcode);
            last1_reg <= s_word.last_in;
        end
    end

    assign chan_in[0]  = s_word.chan_in_0;
    assign chan_in[1]  = s_word.chan_in_1;
    assign chan_in[2]  = s_word.chan_in_2;
    assign chan_in[3]  = s_word.chan_in_3;
    assign unpack_word = byte_order(s_word.packed_in, nbytes, le_reg);

    assign lane_ctrl.load   = ld1;
    assign lane_ctrl.opcode = opcode_t'(s_word.opcode);

    for (genvar i = 0; i < MAX_CHANNELS; i++) begin : g_lane
        pbpu_lane u_lane (
            .aclk     (aclk),
            .ctrl     (lane_ctrl),
            .enable   (CC_BITS'(i) < nchan),
            .chan_in  (chan_in[i]),
            .word_in  (unpack_word),
            .mask     (mask_reg[i]),
            .hb       (hb_reg[i]),
            .word_out (lane_word[i]),
            .chan_out (lane_chan[i])
        );
    end

    assign merge_ctrl.load          = ld2;
    assign merge_ctrl.opcode        = op1_reg;
    assign merge_ctrl.last          = last1_reg;
    assign merge_ctrl.nbytes        = nbytes;
    assign merge_ctrl.little_endian = le_reg;

    pbpu_merge #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_merge (
        .aclk      (aclk),
        .ctrl      (merge_ctrl),
        .lane_word (lane_word),
        .lane_chan (lane_chan),
        .m_word    (m_word)
    );

    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (v1_reg && v2_reg && !m_ready) |-> !s_ready)
        else $error("Input was taken while both stages were full and stalled.");

    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) ##1 m_ready |=> m_valid)
        else $error("An accepted word did not reach the output after two cycles.");

    a_one_direction: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_word.packed_out != '0)) |->
        (m_word.chan_out_0 == '0 && m_word.chan_out_1 == '0 &&
         m_word.chan_out_2 == '0 && m_word.chan_out_3 == '0))
        else $error("Output word carries both packed bytes and channel values.");

endmodule

>>> test/tb_pixel_bitfield_pack_unpack_unit.sv
// Self-checking testbench of the pixel bitfield pack and unpack unit under directed and random traffic.
`timescale 1ns / 1ps

module tb_pixel_bitfield_pack_unpack_unit;
    import pbpu_pkg::*;

    localparam int          CYCLE_LIMIT      = 400000;
    localparam int          MAX_GAP          = 18;
    localparam int          SETTLE_CYCLES    = 4;
    localparam int          RANDOM_PHASES    = 17;
    localparam int          PHASE_ITEMS      = 40;
    localparam logic [2:0]  CFG_UNUSED_INDEX = 3'd7;

    logic                               aclk;
    logic                               aresetn;
    logic                               s_valid;
    logic                               s_ready;
    in_word_t                           s_word;
    logic                               m_valid;
    logic                               m_ready;
    out_word_t                          m_word;
    logic                               cfg_valid;
    logic                               cfg_ready;
    logic [CFG_INDEX_BITS-1:0]          cfg_index;
    logic [WORD_BITS-1:0]               cfg_data;

    logic [WORD_BITS-1:0]               fmt_mask [CHAN_COUNT];
    logic [BPP_BITS-1:0]                fmt_bytes;
    logic [CC_BITS-1:0]                 fmt_channels;
    logic                               fmt_little_endian;

    out_word_t                          expected_pixels [$];
    out_word_t                          oldest_pixel;
    int unsigned                        mismatch_count;
    int unsigned                        cycle_count;
    int unsigned                        hold_off_cycles;
    bit                                 no_idle;

    pixel_bitfield_pack_unpack_unit u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_word    (s_word),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_word    (m_word),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic int highest_set_bit(input logic [WORD_BITS-1:0] m);
        int b;
        for (b = WORD_BITS - 1; b > 0; b--) begin
            if (m[b]) begin
                return b;
            end
        end
        return 0;
    endfunction

    function automatic out_word_t predict_pixel(input in_word_t w);
        out_word_t            r;
        logic [WORD_BITS-1:0] word;
        logic [WORD_BITS-1:0] field;
        logic [7:0]           chans_in [CHAN_COUNT];
        logic [7:0]           chans_out [CHAN_COUNT];
        int                   nb;
        int                   nc;
        int                   hb;
        int                   sh;
        r = '0;
        word = '0;
        nb = (fmt_bytes == 0) ? 1 : (fmt_bytes > 4) ? 4 : int'(fmt_bytes);
        nc = (fmt_channels == 0) ? 1 : (fmt_channels > 4) ? 4 : int'(fmt_channels);
        chans_in[0] = w.chan_in_0;
        chans_in[1] = w.chan_in_1;
        chans_in[2] = w.chan_in_2;
        chans_in[3] = w.chan_in_3;
        for (int i = 0; i < CHAN_COUNT; i++) begin
            chans_out[i] = '0;
        end
        if (w.opcode == OP_PACK) begin
            for (int i = 0; i < nc; i++) begin
                hb = highest_set_bit(fmt_mask[i]);
                field = {24'b0, chans_in[i]};
                field = (hb >= 7) ? (field << (hb - 7)) : (field >> (7 - hb));
                word |= field & fmt_mask[i];
            end
            for (int j = 0; j < nb; j++) begin
                sh = fmt_little_endian ? j : (nb - 1 - j);
                r.packed_out[8*j +: 8] = word[8*sh +: 8];
            end
        end else begin
            for (int j = 0; j < nb; j++) begin
                sh = fmt_little_endian ? j : (nb - 1 - j);
                word[8*sh +: 8] = w.packed_in[8*j +: 8];
            end
            for (int i = 0; i < nc; i++) begin
                hb = highest_set_bit(fmt_mask[i]);
                field = word & fmt_mask[i];
                field = (hb >= 7) ? (field >> (hb - 7)) : (field << (7 - hb));
                chans_out[i] = field[7:0];
            end
        end
        r.chan_out_0 = chans_out[0];
        r.chan_out_1 = chans_out[1];
        r.chan_out_2 = chans_out[2];
        r.chan_out_3 = chans_out[3];
        r.last_out = w.last_in;
        return r;
    endfunction

    function automatic int draw_gap();
        return no_idle ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    function automatic logic [WORD_BITS-1:0] random_mask();
        logic [63:0] span;
        int          width;
        int          pos;
        case ($urandom_range(0, 5))
            0: return '0;
            1: return $urandom();
            2: return 32'h1 << $urandom_range(0, WORD_BITS - 1);
            default: begin
                width = $urandom_range(1, WORD_BITS);
                pos = $urandom_range(0, WORD_BITS - width);
                span = ((64'h1 << width) - 64'h1) << pos;
                return span[WORD_BITS-1:0];
            end
        endcase
    endfunction

    function automatic in_word_t random_pixel();
        in_word_t w;
        w.opcode    = $urandom_range(0, 1) ? OP_UNPACK : OP_PACK;
        w.chan_in_0 = 8'($urandom());
        w.chan_in_1 = 8'($urandom());
        w.chan_in_2 = 8'($urandom());
        w.chan_in_3 = 8'($urandom());
        w.packed_in = $urandom();
        w.last_in   = 1'($urandom_range(0, 1));
        return w;
    endfunction

    function automatic in_word_t make_pixel(input opcode_t op, input logic [7:0] c0,
                                            input logic [7:0] c1, input logic [7:0] c2,
                                            input logic [7:0] c3, input logic [31:0] bytes,
                                            input logic last);
        in_word_t w;
        w.opcode    = op;
        w.chan_in_0 = c0;
        w.chan_in_1 = c1;
        w.chan_in_2 = c2;
        w.chan_in_3 = c3;
        w.packed_in = bytes;
        w.last_in   = last;
        return w;
    endfunction

    task automatic send_pixel(input in_word_t w);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid = 1'b1;
        s_word = w;
        do @(posedge aclk); while (!s_ready);
        expected_pixels.push_back(predict_pixel(w));
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [WORD_BITS-1:0] data);
        s_valid = 1'b0;
        while (expected_pixels.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_MASK_0:          fmt_mask[0] = data;
            CFG_MASK_1:          fmt_mask[1] = data;
            CFG_MASK_2:          fmt_mask[2] = data;
            CFG_MASK_3:          fmt_mask[3] = data;
            CFG_BYTES_PER_PIXEL: fmt_bytes = data[BPP_BITS-1:0];
            CFG_CHANNEL_COUNT:   fmt_channels = data[CC_BITS-1:0];
            CFG_LITTLE_ENDIAN:   fmt_little_endian = data[0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic load_pixel_format(input logic [31:0] m0, input logic [31:0] m1,
                                     input logic [31:0] m2, input logic [31:0] m3,
                                     input logic [31:0] nbytes, input logic [31:0] nchan,
                                     input logic [31:0] le);
        write_reg(CFG_MASK_0, m0);
        write_reg(CFG_MASK_1, m1);
        write_reg(CFG_MASK_2, m2);
        write_reg(CFG_MASK_3, m3);
        write_reg(CFG_BYTES_PER_PIXEL, nbytes);
        write_reg(CFG_CHANNEL_COUNT, nchan);
        write_reg(CFG_LITTLE_ENDIAN, le);
    endtask

    task automatic send_edge_pixels();
        send_pixel(make_pixel(OP_PACK, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 32'h0, 1'b0));
        send_pixel(make_pixel(OP_UNPACK, 8'h0, 8'h0, 8'h0, 8'h0, 32'hFFFF_FFFF, 1'b1));
        send_pixel(random_pixel());
    endtask

    task automatic test_reset_format();
        send_pixel(make_pixel(OP_PACK, 8'h00, 8'h00, 8'h00, 8'h00, 32'hFFFF_FFFF, 1'b1));
        send_pixel(make_pixel(OP_PACK, 8'h81, 8'h42, 8'h24, 8'h18, 32'h0, 1'b0));
        send_pixel(make_pixel(OP_UNPACK, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 32'h0, 1'b0));
        send_pixel(make_pixel(OP_UNPACK, 8'h0, 8'h0, 8'h0, 8'h0, 32'h0C_B3_A5_5A, 1'b1));
        send_edge_pixels();
    endtask

    task automatic test_directed_formats();
        load_pixel_format(32'hFFFF_FFFF, 32'h0, 32'h8000_0000, 32'h1, 4, 4, 0);
        send_edge_pixels();
        load_pixel_format(32'h0000_00F0, 32'h0000_000F, 32'h0000_0300, 32'h0000_FC00,
                          32'hFFFF_FFF8, 32'hFFFF_FFF8, 32'hFFFF_FFFF);
        send_edge_pixels();
        load_pixel_format(32'hFF00_0000, 32'h00FF_0000, 32'h0000_FF00, 32'h0000_00FF,
                          7, 7, 32'hFFFF_FFFE);
        send_edge_pixels();
        load_pixel_format(32'h0000_F800, 32'h0000_07E0, 32'h0000_001F, 32'h0, 2, 5, 0);
        send_edge_pixels();
        load_pixel_format(random_mask(), random_mask(), random_mask(), random_mask(),
                          5, 6, 1);
        write_reg(CFG_UNUSED_INDEX, $urandom());
        send_edge_pixels();
        load_pixel_format(MASK0_RST, MASK1_RST, MASK2_RST, MASK3_RST, 1, 2, 1);
        send_edge_pixels();
    endtask

    task automatic test_back_pressure();
        load_pixel_format(32'h00FF_0000, 32'h0000_FF00, 32'h0000_00FF, 32'hFF00_0000,
                          4, 4, 0);
        no_idle = 1'b1;
        hold_off_cycles = 80;
        repeat (24) send_pixel(random_pixel());
        no_idle = 1'b0;
    endtask

    task automatic test_random_formats();
        logic [31:0] nbytes;
        logic [31:0] nchan;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            nbytes = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 4);
            nchan = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 4);
            load_pixel_format(random_mask(), random_mask(), random_mask(), random_mask(),
                              ($urandom() & ~32'h7) | nbytes,
                              ($urandom() & ~32'h7) | nchan,
                              $urandom());
            no_idle = (p % 4 == 3);
            repeat (PHASE_ITEMS) send_pixel(random_pixel());
            no_idle = 1'b0;
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] expected_value,
                               input logic [31:0] actual_value);
        if (expected_value !== actual_value) begin
            $error("%s: expected 0x%08h, got 0x%08h", name, expected_value, actual_value);
            mismatch_count++;
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_pixels.size() == 0) begin
                $error("result word with no pixel outstanding");
                mismatch_count++;
            end else begin
                oldest_pixel = expected_pixels.pop_front();
                check_field("packed_out", oldest_pixel.packed_out, m_word.packed_out);
                check_field("chan_out_0", oldest_pixel.chan_out_0, m_word.chan_out_0);
                check_field("chan_out_1", oldest_pixel.chan_out_1, m_word.chan_out_1);
                check_field("chan_out_2", oldest_pixel.chan_out_2, m_word.chan_out_2);
                check_field("chan_out_3", oldest_pixel.chan_out_3, m_word.chan_out_3);
                check_field("last_out", oldest_pixel.last_out, m_word.last_out);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        int stall;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (hold_off_cycles > 0) begin
                m_ready = 1'b0;
                repeat (hold_off_cycles) @(negedge aclk);
                hold_off_cycles = 0;
            end
            stall = draw_gap();
            if (stall > 0) begin
                m_ready = 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready = 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_word = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        mismatch_count = 0;
        cycle_count = 0;
        hold_off_cycles = 0;
        no_idle = 1'b0;
        fmt_mask[0] = MASK0_RST;
        fmt_mask[1] = MASK1_RST;
        fmt_mask[2] = MASK2_RST;
        fmt_mask[3] = MASK3_RST;
        fmt_bytes = BPP_RST;
        fmt_channels = CC_RST;
        fmt_little_endian = LE_RST;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_reset_format();
        test_directed_formats();
        test_back_pressure();
        test_random_formats();

        s_valid = 1'b0;
        while (expected_pixels.size() != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
        if (mismatch_count == 0 && expected_pixels.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

>>> pixel_bitfield_pack_unpack_unit.f
sv/pbpu_pkg.sv
sv/pbpu_lane.sv
sv/pbpu_merge.sv
sv/pixel_bitfield_pack_unpack_unit.sv
test/tb_pixel_bitfield_pack_unpack_unit.sv
